FILE: rtl/periodic_grid_gradient_stencil_top_assert.svh
// assertion macros for the periodic grid gradient stencil
// plain text macros, no dependencies
`ifndef PERIODIC_GRID_GRADIENT_STENCIL_TOP_ASSERT_SVH
`define PERIODIC_GRID_GRADIENT_STENCIL_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PGGS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PGGS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pggs_pkg.sv
// shared types, constants and the microcode rom of the gradient stencil
// no dependencies
`timescale 1ns / 1ps

package pggs_pkg;

  // grid geometry
  localparam int MAX_DIM    = 16;
  localparam int MIN_DIM    = 4;
  localparam int COORD_W    = $clog2(MAX_DIM);
  localparam int ADDR_W     = 3 * COORD_W;
  localparam int GRID_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int SIZE_W     = 5;

  // payload widths
  localparam int SAMPLE_W   = 32;
  localparam int FORCE_W    = 32;
  localparam int RECIP_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ORDER_W    = 2;

  // arithmetic widths
  localparam int COEF_W     = 7;
  localparam int ACC_W      = 39;
  localparam int MAG_W      = 38;
  localparam int LO_W       = 32;
  localparam int PPLO_W     = LO_W + RECIP_W;
  localparam int PROD_W     = 72;
  localparam int V_W        = 54;
  localparam int Q_W        = 36;
  localparam int RND_W      = 21;
  localparam int DIG_W      = 4;
  localparam int DIV_STEPS  = Q_W / DIG_W;
  localparam int CNT_W      = 4;
  localparam int SH_2ND     = 17;
  localparam int SH_HIGHER  = 18;

  localparam logic [FORCE_W-1:0] FORCE_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [FORCE_W-1:0] FORCE_NEG_MAX = 32'h8000_0000;

  // microcode addresses
  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_ORD_2ND = 5'd0;
  localparam logic [PC_W-1:0] PC_ORD_4TH = 5'd3;
  localparam logic [PC_W-1:0] PC_ORD_6TH = 5'd8;
  localparam logic [PC_W-1:0] PC_ABS     = 5'd15;
  localparam logic [PC_W-1:0] PC_DIV     = 5'd19;
  localparam logic [PC_W-1:0] PC_WRITE   = 5'd20;

  // stencil order codes
  localparam logic [ORDER_W-1:0] ORD_2ND = 2'd0;
  localparam logic [ORDER_W-1:0] ORD_4TH = 2'd1;
  localparam logic [ORDER_W-1:0] ORD_6TH = 2'd2;
  localparam logic [ORDER_W-1:0] ORD_ALT = 2'd3;

  // axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X  = 3'd0,
    CFG_SIZE_Y  = 3'd1,
    CFG_SIZE_Z  = 3'd2,
    CFG_RECIP_X = 3'd3,
    CFG_RECIP_Y = 3'd4,
    CFG_RECIP_Z = 3'd5,
    CFG_ORDER   = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  typedef enum logic [2:0] {
    DP_NONE   = 3'd0,
    DP_CLR    = 3'd1,
    DP_ABS    = 3'd2,
    DP_MUL_LO = 3'd3,
    DP_MUL_HI = 3'd4,
    DP_ROUND  = 3'd5,
    DP_DIV    = 3'd6,
    DP_WRITE  = 3'd7
  } dp_e;

  typedef enum logic [2:0] {
    J_SEQ   = 3'd0,
    J_GOTO  = 3'd1,
    J_SKIP0 = 3'd2,
    J_LOOP  = 3'd3,
    J_AXIS  = 3'd4
  } jmp_e;

  // one control word
  typedef struct packed {
    logic                     rd_en;
    logic signed [2:0]        ofs;
    logic                     acc_en;
    logic signed [COEF_W-1:0] coef;
    dp_e                      dp;
    jmp_e                     jmp;
    logic [PC_W-1:0]          target;
  } uop_t;

  function automatic uop_t uw(logic rd, logic signed [2:0] ofs, logic acc,
                              logic signed [COEF_W-1:0] coef, dp_e dp, jmp_e jmp,
                              logic [PC_W-1:0] tgt);
    uop_t u;
    u.rd_en  = rd;
    u.ofs    = ofs;
    u.acc_en = acc;
    u.coef   = coef;
    u.dp     = dp;
    u.jmp    = jmp;
    u.target = tgt;
    return u;
  endfunction

  // per-axis program: neighbor reads with weights, then scale and divide (no divide for second order)
  function automatic uop_t ucode(logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // second order: phi[+1] - phi[-1]
      5'd0:  u = uw(1'b1,  3'sd1, 1'b0,   7'sd0, DP_CLR,  J_SEQ,  '0);
      5'd1:  u = uw(1'b1, -3'sd1, 1'b1,   7'sd1, DP_NONE, J_SEQ,  '0);
      5'd2:  u = uw(1'b0,  3'sd0, 1'b1,  -7'sd1, DP_NONE, J_GOTO, PC_ABS);
      // fourth order: 8 d1 - d2
      5'd3:  u = uw(1'b1,  3'sd1, 1'b0,   7'sd0, DP_CLR,  J_SEQ,  '0);
      5'd4:  u = uw(1'b1, -3'sd1, 1'b1,   7'sd8, DP_NONE, J_SEQ,  '0);
      5'd5:  u = uw(1'b1,  3'sd2, 1'b1,  -7'sd8, DP_NONE, J_SEQ,  '0);
      5'd6:  u = uw(1'b1, -3'sd2, 1'b1,  -7'sd1, DP_NONE, J_SEQ,  '0);
      5'd7:  u = uw(1'b0,  3'sd0, 1'b1,   7'sd1, DP_NONE, J_GOTO, PC_ABS);
      // sixth order: 45 d1 - 9 d2 + d3
      5'd8:  u = uw(1'b1,  3'sd1, 1'b0,   7'sd0, DP_CLR,  J_SEQ,  '0);
      5'd9:  u = uw(1'b1, -3'sd1, 1'b1,  7'sd45, DP_NONE, J_SEQ,  '0);
      5'd10: u = uw(1'b1,  3'sd2, 1'b1, -7'sd45, DP_NONE, J_SEQ,  '0);
      5'd11: u = uw(1'b1, -3'sd2, 1'b1,  -7'sd9, DP_NONE, J_SEQ,  '0);
      5'd12: u = uw(1'b1,  3'sd3, 1'b1,   7'sd9, DP_NONE, J_SEQ,  '0);
      5'd13: u = uw(1'b1, -3'sd3, 1'b1,   7'sd1, DP_NONE, J_SEQ,  '0);
      5'd14: u = uw(1'b0,  3'sd0, 1'b1,  -7'sd1, DP_NONE, J_SEQ,  '0);
      // scaling tail shared by all orders
      5'd15: u = uw(1'b0,  3'sd0, 1'b0,   7'sd0, DP_ABS,    J_SEQ,   '0);
      5'd16: u = uw(1'b0,  3'sd0, 1'b0,   7'sd0, DP_MUL_LO, J_SEQ,   '0);
      5'd17: u = uw(1'b0,  3'sd0, 1'b0,   7'sd0, DP_MUL_HI, J_SEQ,   '0);
      5'd18: u = uw(1'b0,  3'sd0, 1'b0,   7'sd0, DP_ROUND,  J_SKIP0, PC_WRITE);
      5'd19: u = uw(1'b0,  3'sd0, 1'b0,   7'sd0, DP_DIV,    J_LOOP,  PC_DIV);
      5'd20: u = uw(1'b0,  3'sd0, 1'b0,   7'sd0, DP_WRITE,  J_AXIS,  '0);
      default: u = uw(1'b0, 3'sd0, 1'b0,  7'sd0, DP_NONE,   J_GOTO,  PC_WRITE);
    endcase
    return u;
  endfunction

  // order code three behaves as sixth order
  function automatic logic [ORDER_W-1:0] ord_norm(logic [ORDER_W-1:0] o);
    return (o == ORD_ALT) ? ORD_6TH : o;
  endfunction

  function automatic logic [PC_W-1:0] ord_entry(logic [ORDER_W-1:0] o);
    logic [PC_W-1:0] pc;
    case (o)
      ORD_2ND: pc = PC_ORD_2ND;
      ORD_4TH: pc = PC_ORD_4TH;
      default: pc = PC_ORD_6TH;
    endcase
    return pc;
  endfunction

  // half of the full divisor d * 2^16, for round to nearest
  function automatic logic [RND_W-1:0] rnd_const(logic [ORDER_W-1:0] o);
    logic [RND_W-1:0] r;
    case (o)
      ORD_2ND: r = RND_W'(2 * 32768);
      ORD_4TH: r = RND_W'(12 * 32768);
      default: r = RND_W'(60 * 32768);
    endcase
    return r;
  endfunction

  // odd part of the divisor left after the power-of-two shift
  function automatic logic [DIG_W-1:0] div_const(logic [ORDER_W-1:0] o);
    logic [DIG_W-1:0] d;
    case (o)
      ORD_2ND: d = 4'd1;
      ORD_4TH: d = 4'd3;
      default: d = 4'd15;
    endcase
    return d;
  endfunction

  // size register clamped to the supported range
  function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] n;
    if (s < SIZE_W'(MIN_DIM)) begin
      n = SIZE_W'(MIN_DIM);
    end else if (s > SIZE_W'(MAX_DIM)) begin
      n = SIZE_W'(MAX_DIM);
    end else begin
      n = s;
    end
    return n;
  endfunction

  // periodic neighbor coordinate (c + k) mod n, with |k| < n
  function automatic logic [COORD_W-1:0] wrap_coord(logic [COORD_W-1:0] c,
                                                    logic signed [2:0] k,
                                                    logic [SIZE_W-1:0] n);
    logic signed [SIZE_W:0] s;
    logic signed [SIZE_W:0] ns;
    ns = $signed({1'b0, n});
    s  = $signed({2'b00, c}) + $signed({{(SIZE_W-2){k[2]}}, k});
    if (s < 0) begin
      s = s + ns;
    end else if (s >= ns) begin
      s = s - ns;
    end
    return s[COORD_W-1:0];
  endfunction

endpackage

FILE: rtl/pggs_if.sv
// channel interfaces of the gradient stencil: input beats, result beats, config writes
// depends on pggs_pkg
`timescale 1ns / 1ps

interface pggs_in_if;
  import pggs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [COORD_W-1:0]         cell_x;
  logic [COORD_W-1:0]         cell_y;
  logic [COORD_W-1:0]         cell_z;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, operation, cell_x, cell_y, cell_z, sample, input ready);
  modport sink   (input valid, operation, cell_x, cell_y, cell_z, sample, output ready);
endinterface

interface pggs_out_if;
  import pggs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FORCE_W-1:0] force_x;
  logic signed [FORCE_W-1:0] force_y;
  logic signed [FORCE_W-1:0] force_z;
  logic                      out_of_range;

  modport source (output valid, force_x, force_y, force_z, out_of_range, input ready);
  modport sink   (input valid, force_x, force_y, force_z, out_of_range, output ready);
endinterface

interface pggs_cfg_if;
  import pggs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/periodic_grid_gradient_stencil_top.sv
// periodic_grid_gradient_stencil_top: microcoded 3d central-difference force over a grid
// depends on pggs_pkg, the pggs_if interfaces and the assertion macro header
// store beat: taken every cycle while idle; out-of-range query skips the microcode
// in-range query: the 2nd, 4th or 6th order program runs on each axis in turn
// next beat taken as the result turns valid; a stalled result holds the next query
// reset: control idle, config at defaults, grid contents undefined until stored
`timescale 1ns / 1ps

`include "periodic_grid_gradient_stencil_top_assert.svh"

module periodic_grid_gradient_stencil_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  pggs_in_if.sink    in_i,
  pggs_out_if.source out_o,
  pggs_cfg_if.sink   cfg_i
);
  import pggs_pkg::*;

  // configuration
  logic [SIZE_W-1:0]  size_x_q, size_y_q, size_z_q;
  logic [RECIP_W-1:0] recip_x_q, recip_y_q, recip_z_q;
  logic [ORDER_W-1:0] order_q;
  logic [SIZE_W-1:0]  nx, ny, nz;
  logic [ORDER_W-1:0] ord;

  // control
  state_e          state_q, state_d;
  logic [PC_W-1:0] step_q, step_d;
  logic [1:0]      axis_q, axis_d;
  logic [CNT_W-1:0] cnt_q;
  logic            bad_q;
  logic            out_valid_q;
  logic            in_acc, in_bad, slot_free, finish, run_act;
  uop_t            uop;

  // datapath
  logic [COORD_W-1:0]       cx_q, cy_q, cz_q;
  logic [COORD_W-1:0]       ax, ay, az;
  logic [COORD_W-1:0]       c_sel;
  logic [SIZE_W-1:0]        n_sel;
  logic [COORD_W-1:0]       c_nb;
  logic [ADDR_W-1:0]        rd_addr, wr_addr;
  logic                     mem_we, mem_re;
  logic [SAMPLE_W-1:0]      grid_mem [GRID_DEPTH];
  logic [SAMPLE_W-1:0]      rd_data_q;
  logic signed [SAMPLE_W-1:0] rd_s;
  logic signed [ACC_W-1:0]  acc_q, acc_term;
  logic                     neg_q;
  logic [MAG_W-1:0]         mag_q;
  logic [RECIP_W-1:0]       recip_sel;
  logic [PPLO_W-1:0]        pp_lo_q;
  logic [MAG_W-1:0]         pp_hi_q;
  logic [PROD_W-1:0]        x_sum;
  logic [V_W-1:0]           v_val;
  logic                     sat_q;
  logic [Q_W-1:0]           div_q;
  logic [DIG_W-1:0]         rem_q;
  logic [DIG_W-1:0]         dvr;
  logic [7:0]               val8, rem_full;
  logic [DIG_W-1:0]         digit;
  logic [FORCE_W-1:0]       force_val;
  logic [FORCE_W-1:0]       frc_x_q, frc_y_q;
  logic [FORCE_W-1:0]       out_fx_q, out_fy_q, out_fz_q;
  logic                     out_oor_q;

  // effective sizes and order
  assign nx  = eff_size(size_x_q);
  assign ny  = eff_size(size_y_q);
  assign nz  = eff_size(size_z_q);
  assign ord = ord_norm(order_q);

  // handshakes
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign in_bad      = ({1'b0, in_i.cell_x} >= nx) || ({1'b0, in_i.cell_y} >= ny) ||
                       ({1'b0, in_i.cell_z} >= nz);
  assign slot_free   = !out_valid_q || out_o.ready;
  assign run_act     = (state_q == ST_RUN) && !bad_q;
  assign uop         = ucode(step_q);

  // config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q  <= SIZE_W'(MAX_DIM);
      size_y_q  <= SIZE_W'(MAX_DIM);
      size_z_q  <= SIZE_W'(MAX_DIM);
      recip_x_q <= RECIP_W'(65536);
      recip_y_q <= RECIP_W'(65536);
      recip_z_q <= RECIP_W'(65536);
      order_q   <= ORD_2ND;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_SIZE_X:  size_x_q  <= cfg_i.data[SIZE_W-1:0];
        CFG_SIZE_Y:  size_y_q  <= cfg_i.data[SIZE_W-1:0];
        CFG_SIZE_Z:  size_z_q  <= cfg_i.data[SIZE_W-1:0];
        CFG_RECIP_X: recip_x_q <= cfg_i.data[RECIP_W-1:0];
        CFG_RECIP_Y: recip_y_q <= cfg_i.data[RECIP_W-1:0];
        CFG_RECIP_Z: recip_z_q <= cfg_i.data[RECIP_W-1:0];
        CFG_ORDER:   order_q   <= cfg_i.data[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: step counter with conditional jumps
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    axis_d  = axis_q;
    finish  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_i.operation == OP_QUERY)) begin
          state_d = ST_RUN;
          step_d  = ord_entry(ord);
          axis_d  = AXIS_X;
        end
      end
      ST_RUN: begin
        if (bad_q) begin
          if (slot_free) begin
            finish  = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          case (uop.jmp)
            J_SEQ:   step_d = step_q + 1'b1;
            J_GOTO:  step_d = uop.target;
            J_SKIP0: step_d = (ord == ORD_2ND) ? uop.target : step_q + 1'b1;
            J_LOOP:  step_d = (cnt_q != '0) ? uop.target : step_q + 1'b1;
            J_AXIS: begin
              if (axis_q != AXIS_Z) begin
                axis_d = axis_q + 1'b1;
                step_d = ord_entry(ord);
              end else if (slot_free) begin
                finish  = 1'b1;
                state_d = ST_IDLE;
              end
            end
            default: step_d = step_q + 1'b1;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      axis_q      <= AXIS_X;
      cnt_q       <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      axis_q  <= axis_d;
      if (in_acc) begin
        bad_q <= in_bad;
      end
      if (run_act && (uop.dp == DP_ROUND)) begin
        cnt_q <= CNT_W'(DIV_STEPS - 1);
      end else if (run_act && (uop.dp == DP_DIV) && (cnt_q != '0)) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // neighbor address with periodic wrap on the active axis
  always_comb begin
    case (axis_q)
      AXIS_X:  begin c_sel = cx_q; n_sel = nx; recip_sel = recip_x_q; end
      AXIS_Y:  begin c_sel = cy_q; n_sel = ny; recip_sel = recip_y_q; end
      default: begin c_sel = cz_q; n_sel = nz; recip_sel = recip_z_q; end
    endcase
  end

  assign c_nb    = wrap_coord(c_sel, uop.ofs, n_sel);
  assign ax      = (axis_q == AXIS_X) ? c_nb : cx_q;
  assign ay      = (axis_q == AXIS_Y) ? c_nb : cy_q;
  assign az      = (axis_q == AXIS_Z) ? c_nb : cz_q;
  assign rd_addr = {ax, ay, az};
  assign wr_addr = {in_i.cell_x, in_i.cell_y, in_i.cell_z};
  assign mem_we  = in_acc && (in_i.operation == OP_STORE) && !in_bad;
  assign mem_re  = run_act && uop.rd_en;

  // grid memory, one port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[wr_addr] <= in_i.sample;
    end else if (mem_re) begin
      rd_data_q <= grid_mem[rd_addr];
    end
  end

  // weighted neighbor term
  assign rd_s     = $signed(rd_data_q);
  assign acc_term = ACC_W'($signed(uop.coef)) * ACC_W'(rd_s);

  // rounding add and power-of-two part of the divisor
  assign x_sum = PROD_W'(pp_lo_q) + PROD_W'({pp_hi_q, {LO_W{1'b0}}}) + PROD_W'(rnd_const(ord));
  assign v_val = (ord == ORD_2ND) ? x_sum[SH_2ND +: V_W] : x_sum[SH_HIGHER +: V_W];

  // one quotient nibble per step by compare against multiples
  assign dvr  = div_const(ord);
  assign val8 = {rem_q, div_q[Q_W-1 -: DIG_W]};
  always_comb begin
    digit = '0;
    for (int j = 1; j < 16; j++) begin
      if (8'(j) * 8'(dvr) <= val8) begin
        digit = digit + 1'b1;
      end
    end
    rem_full = val8 - 8'(digit) * 8'(dvr);
  end

  // negate and saturate the quotient
  always_comb begin
    if (neg_q) begin
      force_val = (sat_q || (div_q > Q_W'(FORCE_POS_MAX))) ? FORCE_POS_MAX : div_q[FORCE_W-1:0];
    end else begin
      force_val = (sat_q || (div_q > Q_W'(FORCE_NEG_MAX))) ? FORCE_NEG_MAX :
                  FORCE_W'(0) - div_q[FORCE_W-1:0];
    end
  end

  // datapath registers driven by the control word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cx_q <= in_i.cell_x;
      cy_q <= in_i.cell_y;
      cz_q <= in_i.cell_z;
    end
    if (run_act) begin
      if (uop.acc_en) begin
        acc_q <= acc_q + acc_term;
      end
      case (uop.dp)
        DP_CLR: acc_q <= '0;
        DP_ABS: begin
          neg_q <= acc_q[ACC_W-1];
          mag_q <= acc_q[ACC_W-1] ? MAG_W'(-acc_q) : MAG_W'(acc_q);
        end
        DP_MUL_LO: pp_lo_q <= PPLO_W'(mag_q[LO_W-1:0]) * PPLO_W'(recip_sel);
        DP_MUL_HI: pp_hi_q <= MAG_W'(mag_q[MAG_W-1:LO_W]) * MAG_W'(recip_sel);
        DP_ROUND: begin
          sat_q <= |v_val[V_W-1:Q_W];
          div_q <= v_val[Q_W-1:0];
          rem_q <= '0;
        end
        DP_DIV: begin
          div_q <= {div_q[Q_W-DIG_W-1:0], digit};
          rem_q <= rem_full[DIG_W-1:0];
        end
        DP_WRITE: begin
          if (axis_q == AXIS_X) begin
            frc_x_q <= force_val;
          end
          if (axis_q == AXIS_Y) begin
            frc_y_q <= force_val;
          end
        end
        default: ;
      endcase
    end
    // result beat
    if (finish) begin
      out_fx_q  <= bad_q ? '0 : frc_x_q;
      out_fy_q  <= bad_q ? '0 : frc_y_q;
      out_fz_q  <= bad_q ? '0 : force_val;
      out_oor_q <= bad_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.force_x      = $signed(out_fx_q);
  assign out_o.force_y      = $signed(out_fy_q);
  assign out_o.force_z      = $signed(out_fz_q);
  assign out_o.out_of_range = out_oor_q;

  // checks
  `PGGS_ASSERT_NXT(a_store_no_result, clk_i, rst_ni, in_acc && (in_i.operation == OP_STORE) && !out_valid_q, !out_valid_q, "store beat raised a result")
  `PGGS_ASSERT_IMP(a_acc_after_read, clk_i, rst_ni, run_act && uop.acc_en, $past(uop.rd_en), "accumulate without a read in the step before")
  `PGGS_ASSERT_IMP(a_oor_zero_force, clk_i, rst_ni, out_valid_q && out_oor_q, (out_fx_q == '0) && (out_fy_q == '0) && (out_fz_q == '0), "out-of-range result carries a force")
  `PGGS_ASSERT_IMP(a_axis_range, clk_i, rst_ni, state_q == ST_RUN, axis_q <= AXIS_Z, "axis counter past z")

endmodule
